### hdl/epc_pkg.sv
`default_nettype none

package epc_pkg;

   localparam int EPOCH_W      = 32;
   localparam int SECOND_W     = 6;
   localparam int MINUTE_W     = 6;
   localparam int HOUR_W       = 5;
   localparam int WEEKDAY_W    = 3;
   localparam int YEAR_W       = 8;
   localparam int YDAY_W       = 9;
   localparam int MONTH_W      = 4;
   localparam int MDAY_W       = 5;

   // seconds per day = 2^7 * 675
   localparam int DAY_SHIFT    = 7;
   localparam int DAY_ODD_DIV  = 675;
   localparam int DAY_HIGH_W   = EPOCH_W - DAY_SHIFT;
   localparam int DAYS_W       = 16;
   localparam int SOD_W        = 17;
   localparam int MINS_W       = 11;

   localparam int SECS_PER_MIN = 60;
   localparam int MINS_PER_HR  = 60;
   localparam int DAYS_PER_WK  = 7;
   localparam int WEEKDAY_OFS  = 4;
   localparam int WK_QUOT_W    = 13;

   localparam int DAYS_PER_QUAD = 1461;
   localparam int QUAD_X_W      = DAYS_W + 2;
   localparam int YIDX_W        = 8;
   localparam int YREM_W        = 11;
   localparam int YEAR_BASE     = 70;

   localparam int FEB_LAST_YDAY = 58;
   localparam int NUM_MONTHS    = 12;

   // first shifted day of each month: (m * 367 + 5) / 12
   localparam logic [YDAY_W-1:0] MONTH_START [NUM_MONTHS] = '{
      9'd0,   9'd31,  9'd61,  9'd92,  9'd122, 9'd153,
      9'd183, 9'd214, 9'd245, 9'd275, 9'd306, 9'd336
   };

   typedef struct packed {
      logic load_mul;
      logic load_fix;
   } div_en_type;

endpackage

`default_nettype wire

### hdl/epc_if.sv
`default_nettype none

interface epc_req_if import epc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [EPOCH_W-1:0] epoch_seconds;

   modport source (output valid, output epoch_seconds, input ready);
   modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface epc_rsp_if import epc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [SECOND_W-1:0]  second;
   logic [MINUTE_W-1:0]  minute;
   logic [HOUR_W-1:0]    hour;
   logic [WEEKDAY_W-1:0] weekday;
   logic [YEAR_W-1:0]    years_since_1900;
   logic [YDAY_W-1:0]    day_of_year;
   logic [MONTH_W-1:0]   month;
   logic [MDAY_W-1:0]    day_of_month;

   modport source (
      output valid, output second, output minute, output hour, output weekday,
      output years_since_1900, output day_of_year, output month,
      output day_of_month, input ready
   );
   modport sink (
      input valid, input second, input minute, input hour, input weekday,
      input years_since_1900, input day_of_year, input month,
      input day_of_month, output ready
   );
endinterface

`default_nettype wire

### hdl/epc_cdiv.sv
`default_nettype none

module epc_cdiv import epc_pkg::*; #(
   parameter int X_W     = 17,
   parameter int DIVISOR = 60,
   parameter int Q_W     = 11
) (
   input  wire logic                         clock,
   input  wire div_en_type                   en,
   input  wire logic [X_W-1:0]               dividend,
   output logic      [Q_W-1:0]               quotient,
   output logic      [$clog2(DIVISOR)-1:0]   remainder
);

   localparam int R_W = $clog2(DIVISOR);
   localparam logic [X_W-1:0] RECIP = X_W'((64'd1 << X_W) / 64'(DIVISOR));

   logic [2*X_W-1:0] prod;
   logic [Q_W-1:0]   q0_ff, q0_in;
   logic [X_W-1:0]   x_ff;
   logic [X_W-1:0]   r0;
   logic             fix;
   logic [Q_W-1:0]   q_ff, q_in;
   logic [R_W-1:0]   r_ff, r_in;

   // estimate is exact or one low
   always_comb begin
      prod  = (2*X_W)'(dividend) * (2*X_W)'(RECIP);
      q0_in = Q_W'(prod[2*X_W-1:X_W]);
   end

   always_comb begin
      r0   = x_ff - X_W'(q0_ff) * X_W'(DIVISOR);
      fix  = r0 >= X_W'(DIVISOR);
      q_in = fix ? q0_ff + Q_W'(1) : q0_ff;
      r_in = fix ? R_W'(r0 - X_W'(DIVISOR)) : R_W'(r0);
   end

   always_ff @(posedge clock) begin
      if (en.load_mul) begin
         q0_ff <= q0_in;
         x_ff  <= dividend;
      end
      if (en.load_fix) begin
         q_ff <= q_in;
         r_ff <= r_in;
      end
   end

   assign quotient  = q_ff;
   assign remainder = r_ff;

endmodule

`default_nettype wire

### hdl/epoch_seconds_to_calendar.sv
// Epoch seconds to UTC calendar converter.
// req_chan carries a 32-bit unsigned count of seconds since 1970-01-01 UTC;
// rsp_chan returns second, minute, hour, weekday (Sunday = 0), years since
// 1900, day of year, month (January = 0) and day of month for it. One
// response comes back for every request, in order. Leap years follow the
// every-fourth-year rule, so dates past February 2100 are one day behind.
// The block is a six-stage pipeline, and one request can enter every cycle
// unless a stall on rsp_chan.ready has left every stage occupied.
// Each stage pair is a constant-reciprocal multiply followed by a
// remainder correction (seconds to days, day seconds to minutes, minutes to
// hours, days to weekday and to four-year cycle); the last stage places the
// day in its month and holds the response register.
// With rsp_chan.ready low, full stages with no empty stage downstream hold;
// others keep filling, and req_chan.ready is high until all stages are full.
// Synchronous reset empties the pipeline; nothing else is kept.
`default_nettype none

module epoch_seconds_to_calendar import epc_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   epc_req_if.sink     req_chan,
   epc_rsp_if.source   rsp_chan
);

   localparam int NUM_STAGES = 6;

   logic [NUM_STAGES-1:0] valid_ff, valid_in;
   logic [NUM_STAGES-1:0] stage_en;

   always_comb begin
      stage_en[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_chan.ready;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         stage_en[i] = !valid_ff[i] || stage_en[i+1];
      end
      valid_in = {valid_ff[NUM_STAGES-2:0], req_chan.valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < NUM_STAGES; i++) begin
            if (stage_en[i]) begin
               valid_ff[i] <= valid_in[i];
            end
         end
      end
   end

   assign req_chan.ready = stage_en[0];

   // seconds to days and seconds of day
   div_en_type                 en_a, en_b, en_c;
   logic [DAY_SHIFT-1:0]       low_s1_ff, low_s2_ff;
   logic [DAYS_W-1:0]          days;
   logic [$clog2(DAY_ODD_DIV)-1:0] day_rem;
   logic [SOD_W-1:0]           sod;
   logic [DAYS_W-1:0]          wk_dividend;

   assign en_a = '{load_mul: stage_en[0], load_fix: stage_en[1]};
   assign en_b = '{load_mul: stage_en[2], load_fix: stage_en[3]};
   assign en_c = '{load_mul: stage_en[4], load_fix: stage_en[5]};

   epc_cdiv #(.X_W(DAY_HIGH_W), .DIVISOR(DAY_ODD_DIV), .Q_W(DAYS_W)) u_day_div (
      .clock     (clock),
      .en        (en_a),
      .dividend  (req_chan.epoch_seconds[EPOCH_W-1:DAY_SHIFT]),
      .quotient  (days),
      .remainder (day_rem)
   );

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         low_s1_ff <= req_chan.epoch_seconds[DAY_SHIFT-1:0];
      end
      if (stage_en[1]) begin
         low_s2_ff <= low_s1_ff;
      end
   end

   assign sod         = {day_rem, low_s2_ff};
   assign wk_dividend = days + DAYS_W'(WEEKDAY_OFS);

   // minutes, weekday, four-year cycle
   logic [MINS_W-1:0]    mins;
   logic [SECOND_W-1:0]  sec;
   logic [WEEKDAY_W-1:0] wday;
   logic [YIDX_W-1:0]    yidx;
   logic [YREM_W-1:0]    yrem;

   epc_cdiv #(.X_W(SOD_W), .DIVISOR(SECS_PER_MIN), .Q_W(MINS_W)) u_min_div (
      .clock     (clock),
      .en        (en_b),
      .dividend  (sod),
      .quotient  (mins),
      .remainder (sec)
   );

   epc_cdiv #(.X_W(DAYS_W), .DIVISOR(DAYS_PER_WK), .Q_W(WK_QUOT_W)) u_wk_div (
      .clock     (clock),
      .en        (en_b),
      .dividend  (wk_dividend),
      .quotient  (),
      .remainder (wday)
   );

   epc_cdiv #(.X_W(QUAD_X_W), .DIVISOR(DAYS_PER_QUAD), .Q_W(YIDX_W)) u_year_div (
      .clock     (clock),
      .en        (en_b),
      .dividend  ({days, 2'b10}),
      .quotient  (yidx),
      .remainder (yrem)
   );

   // hours and minute of hour
   logic [HOUR_W-1:0]   hour;
   logic [MINUTE_W-1:0] minute;

   epc_cdiv #(.X_W(MINS_W), .DIVISOR(MINS_PER_HR), .Q_W(HOUR_W)) u_hour_div (
      .clock     (clock),
      .en        (en_c),
      .dividend  (mins),
      .quotient  (hour),
      .remainder (minute)
   );

   // day of year and shifted day
   logic [YREM_W-1:0]    yday_x4;
   logic [YDAY_W-1:0]    yday_in, adj_in;
   logic                 leap;
   logic [YIDX_W-1:0]    yidx_s5_ff;
   logic [YDAY_W-1:0]    yday_s5_ff, adj_s5_ff;
   logic [WEEKDAY_W-1:0] wday_s5_ff;
   logic [SECOND_W-1:0]  sec_s5_ff;

   always_comb begin
      yday_x4 = yrem + YREM_W'(yidx[1:0]) - YREM_W'(2)
              - ((yidx[1:0] == 2'b11) ? YREM_W'(4) : YREM_W'(0));
      yday_in = YDAY_W'(yday_x4 >> 2);
      leap    = yidx[1:0] == 2'b10;
      adj_in  = yday_in;
      if (yday_in > YDAY_W'(FEB_LAST_YDAY) + YDAY_W'(leap)) begin
         adj_in = yday_in + (leap ? YDAY_W'(1) : YDAY_W'(2));
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         yidx_s5_ff <= yidx;
         yday_s5_ff <= yday_in;
         adj_s5_ff  <= adj_in;
         wday_s5_ff <= wday;
         sec_s5_ff  <= sec;
      end
   end

   // month and day of month
   logic [MONTH_W-1:0]   mon_in;
   logic [MDAY_W-1:0]    mday_in;
   logic [YEAR_W-1:0]    year_ff;
   logic [YDAY_W-1:0]    yday_ff;
   logic [MONTH_W-1:0]   mon_ff;
   logic [MDAY_W-1:0]    mday_ff;
   logic [WEEKDAY_W-1:0] wday_ff;
   logic [SECOND_W-1:0]  sec_ff;

   always_comb begin
      mon_in = '0;
      for (int m = 1; m < NUM_MONTHS; m++) begin
         if (adj_s5_ff >= MONTH_START[m]) begin
            mon_in = mon_in + MONTH_W'(1);
         end
      end
      mday_in = MDAY_W'(adj_s5_ff + YDAY_W'(1) - MONTH_START[mon_in]);
   end

   always_ff @(posedge clock) begin
      if (stage_en[5]) begin
         year_ff <= YEAR_W'(yidx_s5_ff + YIDX_W'(YEAR_BASE));
         yday_ff <= yday_s5_ff;
         mon_ff  <= mon_in;
         mday_ff <= mday_in;
         wday_ff <= wday_s5_ff;
         sec_ff  <= sec_s5_ff;
      end
   end

   assign rsp_chan.valid            = valid_ff[NUM_STAGES-1];
   assign rsp_chan.second           = sec_ff;
   assign rsp_chan.minute           = minute;
   assign rsp_chan.hour             = hour;
   assign rsp_chan.weekday          = wday_ff;
   assign rsp_chan.years_since_1900 = year_ff;
   assign rsp_chan.day_of_year      = yday_ff;
   assign rsp_chan.month            = mon_ff;
   assign rsp_chan.day_of_month     = mday_ff;

endmodule

`default_nettype wire
